// ===== hdl/sfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Synthesizer frequency word calculator package
// Constants and reciprocal factors shared by the tuning-word pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sfwc_pkg;

   localparam int HZ_W      = 33;
   localparam int DDS_W     = 32;
   localparam int PLL_W     = 31;
   localparam int BYTE_W    = 8;
   localparam int K_W       = 3;
   localparam int BAND_W    = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [HZ_W-1:0] FREQ_MIN_HZ       = 33'd9000;
   localparam logic [HZ_W-1:0] FREQ_MAX_HZ       = 33'd6000000000;
   localparam logic [HZ_W-1:0] LOW_BAND_MAX_HZ   = 33'd25000000;
   localparam logic [HZ_W-1:0] SYNTH_LIMIT_HZ    = 33'd6000000000;
   localparam logic [HZ_W-1:0] LOW_BAND_SYNTH_HZ = 33'd100000000;
   localparam int              MAX_K             = 7;

   // DDS word: floor(hz * 2^32 / 1e8) = floor(hz * 2^24 / 390625), taken as
   // (hz * ceil(2^68 / 390625)) >> 44, exact for hz below 2^25.
   localparam int                DDS_HZ_W    = 25;
   localparam int                DDS_SHIFT   = 44;
   localparam logic [69:0]       DDS_RECIP_F = ((70'd1 << 68) + 70'd390624) / 70'd390625;
   localparam logic [49:0]       DDS_RECIP   = DDS_RECIP_F[49:0];

   // Megahertz count: floor((v >> 6) / 15625), exact for v >> 6 below 2^27.
   localparam int                T_W         = 13;
   localparam int                T_SHIFT     = 41;
   localparam logic [41:0]       T_RECIP_F   = ((42'd1 << 41) + 42'd15624) / 42'd15625;
   localparam logic [27:0]       T_RECIP     = T_RECIP_F[27:0];

   // PLL step: floor(t / 25) = (t * ceil(2^18 / 25)) >> 18 for t up to 6000.
   localparam int                Q_W         = 8;
   localparam int                Q_SHIFT     = 18;
   localparam logic [18:0]       Q_RECIP_F   = ((19'd1 << 18) + 19'd24) / 19'd25;
   localparam logic [13:0]       Q_RECIP     = Q_RECIP_F[13:0];
   localparam logic [12:0]       PLL_STEP    = 13'd25;
   localparam logic [11:0]       PLL_FRAC_SCALE = 12'd100;

   localparam logic [BYTE_W-1:0] DIV_BASE     = 8'h8F;
   localparam logic [BYTE_W-1:0] CTRL_LOW_ON  = 8'h45;
   localparam logic [BYTE_W-1:0] CTRL_DEFAULT = 8'h44;
   localparam logic [BYTE_W-1:0] LEVEL_OFF    = 8'hDC;
   localparam logic [BYTE_W-1:0] LEVEL_RESET  = 8'd252;

   localparam logic [BAND_W-1:0] BAND_HIGH = 2'd0;
   localparam logic [BAND_W-1:0] BAND_LOW  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_OFF  = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_ENABLED = 1'b0,
      CSR_SYNTH_LEVEL    = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hdl/synth_frequency_word_calc_unit.sv =====
// ----------------------------------------------------------------------------
// Synthesizer frequency word calculator
// Clamps a requested frequency and produces DDS, divider and PLL words.
// ----------------------------------------------------------------------------
// The unit takes one request transfer per clock cycle while req_stall is low,
// and passes it through a five-stage pipeline whose depth is set by the
// reciprocal multiplies of the DDS word, the megahertz count and the PLL step.
// A stalled result holds the pipeline only as far back as there are no empty
// stages. The configuration registers are to be written only while no request
// is in flight; the unit itself does not enforce this.
`default_nettype none

module synth_frequency_word_calc_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [sfwc_pkg::HZ_W-1:0]      req_freq_hz,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [sfwc_pkg::HZ_W-1:0]           rsp_clamped_freq_hz,
   output logic                                rsp_low_band,
   output logic [sfwc_pkg::DDS_W-1:0]          rsp_dds_word,
   output logic [sfwc_pkg::BYTE_W-1:0]         rsp_divider_byte,
   output logic [sfwc_pkg::PLL_W-1:0]          rsp_pll_word,
   output logic [sfwc_pkg::BYTE_W-1:0]         rsp_control_byte,
   output logic [sfwc_pkg::BYTE_W-1:0]         rsp_level_byte,
   output logic [sfwc_pkg::BAND_W-1:0]         rsp_band_switch,
   input  wire logic                           csr_we,
   input  wire logic [sfwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sfwc_pkg::BYTE_W-1:0]    csr_wdata
);

   import sfwc_pkg::*;

   logic                output_enabled_ff;
   logic [BYTE_W-1:0]   synth_level_ff;

   logic                ld1, ld2, ld3, ld4, ld5;

   logic [HZ_W-1:0]     s1_hz_in, s1_synth_in;
   logic                s1_low_in;
   logic                s1_valid_ff, s1_low_ff;
   logic [HZ_W-1:0]     s1_hz_ff, s1_synth_ff;

   logic [K_W-1:0]      s2_k_in;
   logic [49:0]         s2_plo_in, s2_phi_in;
   logic                s2_valid_ff, s2_low_ff;
   logic [HZ_W-1:0]     s2_hz_ff, s2_synth_ff;
   logic [K_W-1:0]      s2_k_ff;
   logic [49:0]         s2_plo_ff, s2_phi_ff;

   logic [HZ_W-1:0]     s3_scaled;
   logic [54:0]         s3_tprod;
   logic [74:0]         s3_dsum;
   logic [DDS_W-1:0]    s3_dds_in;
   logic [T_W-1:0]      s3_t_in;
   logic                s3_valid_ff, s3_low_ff;
   logic [HZ_W-1:0]     s3_hz_ff;
   logic [K_W-1:0]      s3_k_ff;
   logic [DDS_W-1:0]    s3_dds_ff;
   logic [T_W-1:0]      s3_t_ff;

   logic [26:0]         s4_qprod;
   logic [Q_W-1:0]      s4_q_in;
   logic                s4_valid_ff, s4_low_ff;
   logic [HZ_W-1:0]     s4_hz_ff;
   logic [K_W-1:0]      s4_k_ff;
   logic [DDS_W-1:0]    s4_dds_ff;
   logic [T_W-1:0]      s4_t_ff;
   logic [Q_W-1:0]      s4_q_ff;

   logic [T_W-1:0]      s5_rem;
   logic [11:0]         s5_frac;
   logic [PLL_W-1:0]    s5_pll_in;
   logic [BYTE_W-1:0]   s5_div_in, s5_ctrl_in, s5_level_in;
   logic [BAND_W-1:0]   s5_band_in;
   logic                rsp_valid_ff, rsp_low_band_ff;
   logic [HZ_W-1:0]     rsp_hz_ff;
   logic [DDS_W-1:0]    rsp_dds_ff;
   logic [BYTE_W-1:0]   rsp_div_ff, rsp_ctrl_ff, rsp_level_ff;
   logic [PLL_W-1:0]    rsp_pll_ff;
   logic [BAND_W-1:0]   rsp_band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_enabled_ff <= 1'b0;
         synth_level_ff    <= LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OUTPUT_ENABLED: output_enabled_ff <= csr_wdata[0];
            CSR_SYNTH_LEVEL:    synth_level_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ld5       = !rsp_valid_ff || !rsp_stall;
   assign ld4       = !s4_valid_ff || ld5;
   assign ld3       = !s3_valid_ff || ld4;
   assign ld2       = !s2_valid_ff || ld3;
   assign ld1       = !s1_valid_ff || ld2;
   assign req_stall = !ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff  <= req_valid;
         if (ld2) s2_valid_ff  <= s1_valid_ff;
         if (ld3) s3_valid_ff  <= s2_valid_ff;
         if (ld4) s4_valid_ff  <= s3_valid_ff;
         if (ld5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: clamp and band selection.
   always_comb begin
      if (req_freq_hz < FREQ_MIN_HZ) begin
         s1_hz_in = FREQ_MIN_HZ;
      end else if (req_freq_hz > FREQ_MAX_HZ) begin
         s1_hz_in = FREQ_MAX_HZ;
      end else begin
         s1_hz_in = req_freq_hz;
      end
      s1_low_in   = s1_hz_in <= LOW_BAND_MAX_HZ;
      s1_synth_in = s1_low_in ? LOW_BAND_SYNTH_HZ : s1_hz_in;
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_hz_ff    <= s1_hz_in;
         s1_low_ff   <= s1_low_in;
         s1_synth_ff <= s1_synth_in;
      end
   end

   // Stage 2: divider exponent and DDS partial products.
   always_comb begin
      s2_k_in = '0;
      for (int j = 1; j <= MAX_K; j++) begin
         if (s1_synth_ff <= (SYNTH_LIMIT_HZ >> j)) begin
            s2_k_in = K_W'(j);
         end
      end
      s2_plo_in = {25'd0, s1_hz_ff[DDS_HZ_W-1:0]} * {25'd0, DDS_RECIP[24:0]};
      s2_phi_in = {25'd0, s1_hz_ff[DDS_HZ_W-1:0]} * {25'd0, DDS_RECIP[49:25]};
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_hz_ff    <= s1_hz_ff;
         s2_low_ff   <= s1_low_ff;
         s2_synth_ff <= s1_synth_ff;
         s2_k_ff     <= s2_k_in;
         s2_plo_ff   <= s2_plo_in;
         s2_phi_ff   <= s2_phi_in;
      end
   end

   // Stage 3: megahertz count and DDS word.
   always_comb begin
      s3_scaled = s2_synth_ff << s2_k_ff;
      s3_tprod  = {28'd0, s3_scaled[HZ_W-1:6]} * {27'd0, T_RECIP};
      s3_t_in   = s3_tprod[T_SHIFT+T_W-1:T_SHIFT];
      s3_dsum   = {s2_phi_ff, 25'd0} + {25'd0, s2_plo_ff};
      s3_dds_in = s2_low_ff ? {1'b0, s3_dsum[74:DDS_SHIFT]} : '0;
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_hz_ff  <= s2_hz_ff;
         s3_low_ff <= s2_low_ff;
         s3_k_ff   <= s2_k_ff;
         s3_dds_ff <= s3_dds_in;
         s3_t_ff   <= s3_t_in;
      end
   end

   // Stage 4: integer part of the PLL word.
   always_comb begin
      s4_qprod = {14'd0, s3_t_ff} * {13'd0, Q_RECIP};
      s4_q_in  = s4_qprod[Q_SHIFT+Q_W-1:Q_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_hz_ff  <= s3_hz_ff;
         s4_low_ff <= s3_low_ff;
         s4_k_ff   <= s3_k_ff;
         s4_dds_ff <= s3_dds_ff;
         s4_t_ff   <= s3_t_ff;
         s4_q_ff   <= s4_q_in;
      end
   end

   // Stage 5: fraction, PLL word assembly and control bytes.
   always_comb begin
      s5_rem      = s4_t_ff - ({5'd0, s4_q_ff} * PLL_STEP);
      s5_frac     = {7'd0, s5_rem[4:0]} * PLL_FRAC_SCALE;
      s5_pll_in   = {8'd0, s4_q_ff, 15'd0} + {16'd0, s5_frac, 3'd0};
      s5_div_in   = DIV_BASE + {1'b0, s4_k_ff, 4'd0};
      s5_ctrl_in  = (s4_low_ff && output_enabled_ff) ? CTRL_LOW_ON : CTRL_DEFAULT;
      s5_level_in = (!s4_low_ff && output_enabled_ff) ? synth_level_ff : LEVEL_OFF;
      if (!output_enabled_ff) begin
         s5_band_in = BAND_OFF;
      end else if (s4_low_ff) begin
         s5_band_in = BAND_LOW;
      end else begin
         s5_band_in = BAND_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (ld5) begin
         rsp_hz_ff       <= s4_hz_ff;
         rsp_low_band_ff <= s4_low_ff;
         rsp_dds_ff      <= s4_dds_ff;
         rsp_div_ff      <= s5_div_in;
         rsp_pll_ff      <= s5_pll_in;
         rsp_ctrl_ff     <= s5_ctrl_in;
         rsp_level_ff    <= s5_level_in;
         rsp_band_ff     <= s5_band_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_clamped_freq_hz = rsp_hz_ff;
   assign rsp_low_band        = rsp_low_band_ff;
   assign rsp_dds_word        = rsp_dds_ff;
   assign rsp_divider_byte    = rsp_div_ff;
   assign rsp_pll_word        = rsp_pll_ff;
   assign rsp_control_byte    = rsp_ctrl_ff;
   assign rsp_level_byte      = rsp_level_ff;
   assign rsp_band_switch     = rsp_band_ff;

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clamped_freq_hz >= FREQ_MIN_HZ
                     && rsp_clamped_freq_hz <= FREQ_MAX_HZ))
      else $error("result frequency outside the clamped range");

   a_high_band_dds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_low_band) |-> (rsp_dds_word == '0))
      else $error("nonzero DDS word in the high band");

   a_low_band_pll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_low_band) |->
         (rsp_divider_byte == 8'hDF && rsp_pll_word == 31'(128 << 15)))
      else $error("low band PLL setting is not the fixed 100 MHz word");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transfer did not enter the first stage");

endmodule

`default_nettype wire
